/* sv/irae_pkg.sv */
// Shared types, opcode codes and instruction-field helpers for the IR to AArch64 encoder.
package irae_pkg;

    // Register ids at or above this limit fold onto register 31
    localparam int REG_LIMIT = 29;

    localparam logic [4:0] REG_ZR = 5'd31;

    // Intermediate-code opcodes
    localparam logic [4:0] CMD_CONST  = 5'd0;
    localparam logic [4:0] CMD_MOV    = 5'd1;
    localparam logic [4:0] CMD_ADD    = 5'd2;
    localparam logic [4:0] CMD_SUB    = 5'd3;
    localparam logic [4:0] CMD_MUL    = 5'd4;
    localparam logic [4:0] CMD_NEG    = 5'd5;
    localparam logic [4:0] CMD_NOT    = 5'd6;
    localparam logic [4:0] CMD_AND    = 5'd7;
    localparam logic [4:0] CMD_OR     = 5'd8;
    localparam logic [4:0] CMD_XOR    = 5'd9;
    localparam logic [4:0] CMD_EQ     = 5'd10;
    localparam logic [4:0] CMD_NE     = 5'd11;
    localparam logic [4:0] CMD_LT     = 5'd12;
    localparam logic [4:0] CMD_LE     = 5'd13;
    localparam logic [4:0] CMD_GT     = 5'd14;
    localparam logic [4:0] CMD_GE     = 5'd15;
    localparam logic [4:0] CMD_BR     = 5'd16;
    localparam logic [4:0] CMD_BRCOND = 5'd17;
    localparam logic [4:0] CMD_RET    = 5'd18;
    localparam logic [4:0] CMD_CALL   = 5'd19;
    localparam logic [4:0] CMD_ALLOCA = 5'd20;
    localparam logic [4:0] CMD_LOAD   = 5'd21;
    localparam logic [4:0] CMD_STORE  = 5'd22;

    // Fixed instruction words
    localparam logic [31:0] W_RET     = 32'hD65F03C0;
    localparam logic [31:0] W_NOP     = 32'hD503201F;
    localparam logic [31:0] W_ALLOCA  = 32'hD10043FF;
    localparam logic [31:0] W_B       = 32'h14000000;
    localparam logic [31:0] W_B_SKIP  = 32'h14000002;
    localparam logic [31:0] W_BNE     = 32'h54000041;
    localparam logic [31:0] W_BL      = 32'h94000000;
    localparam logic [31:0] W_ERROR   = 32'h00000000;

    // Major opcode bytes (bits 30:24 with the 64-bit flag on top)
    localparam logic [6:0] OP_ADD  = 7'h0B;
    localparam logic [6:0] OP_SUB  = 7'h4B;
    localparam logic [6:0] OP_MADD = 7'h1B;
    localparam logic [6:0] OP_AND  = 7'h0A;
    localparam logic [6:0] OP_ORR  = 7'h2A;
    localparam logic [6:0] OP_EOR  = 7'h4A;
    localparam logic [7:0] OP_LDR  = 8'hF9;
    localparam logic [7:0] OP_STR  = 8'hF8;
    localparam logic [5:0] OP_MOVW = 6'h25;
    localparam logic [1:0] OPC_MOVZ = 2'd2;
    localparam logic [1:0] OPC_MOVK = 2'd3;

    typedef struct packed {
        logic [4:0]         command;
        logic               dest_present;
        logic [7:0]         dest_id;
        logic               first_is_reg;
        logic [7:0]         first_id;
        logic               second_is_reg;
        logic [7:0]         second_id;
        logic               imm_valid;
        logic signed [63:0] imm_value;
    } item_t;

    // Up to four words for one item, plus where the list ends
    typedef struct packed {
        logic [3:0][31:0] words;
        logic [1:0]       last_idx;
        logic             err;
        logic             reloc;
    } plan_t;

    function automatic logic [4:0] map_reg(input logic is_reg, input logic [7:0] id);
        if (is_reg && (id < 8'(REG_LIMIT)) && (id < 8'd31)) begin
            return id[4:0];
        end
        return REG_ZR;
    endfunction

    // Three-register data-processing form
    function automatic logic [31:0] rrr(input logic [6:0] top, input logic [4:0] rd,
                                        input logic [4:0] rn, input logic [4:0] rm);
        return {1'b1, top, 3'b000, rm, 6'b000000, rn, rd};
    endfunction

    // SUBS XZR, Rn, Rm
    function automatic logic [31:0] cmp_word(input logic [4:0] rn, input logic [4:0] rm);
        return {11'b11101011000, rm, 6'b000000, rn, REG_ZR};
    endfunction

    // CSINC Rd, XZR, XZR, inverted condition
    function automatic logic [31:0] cset_word(input logic [4:0] rd, input logic [4:0] cmd);
        logic [3:0] inv;
        case (cmd)
            CMD_EQ:  inv = 4'd1;
            CMD_NE:  inv = 4'd0;
            CMD_LT:  inv = 4'd10;
            CMD_LE:  inv = 4'd12;
            CMD_GT:  inv = 4'd13;
            CMD_GE:  inv = 4'd11;
            default: inv = 4'd0;
        endcase
        return {16'h9A9F, inv, 7'b0111111, rd};
    endfunction

    function automatic logic [31:0] mov_wide(input logic [1:0] opc, input logic [4:0] rd,
                                             input logic [15:0] imm16, input logic [1:0] hw);
        return {1'b1, opc, OP_MOVW, hw, imm16, rd};
    endfunction

endpackage

/* sv/ir_to_aarch64_encoder.sv */
// Top level: input register, word sequencer and output register around the encoder.
//
// Turns one intermediate-code instruction into one to four 64-bit-form AArch64
// instruction words, one output beat per word, m_last marking the final beat of
// each instruction. An instruction holds the input register until its last word
// moves out, since the single output register drains one word per cycle unless
// m_ready stalls it; so most opcodes sustain one item per cycle when unstalled,
// compares give two words, conditional branches three and constants one to four
// (one plus a word per nonzero upper halfword). A beat passes through the input
// register, then the output register. A constant with no immediate gives a single
// beat with m_error set and a zero word; a call's BL beat carries m_needs_reloc.
// Register ids of 29 or more, and non-register operands, encode as register 31.
module ir_to_aarch64_encoder
    import irae_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_command,
    input  logic               s_dest_present,
    input  logic [7:0]         s_dest_id,
    input  logic               s_first_is_reg,
    input  logic [7:0]         s_first_id,
    input  logic               s_second_is_reg,
    input  logic [7:0]         s_second_id,
    input  logic               s_imm_valid,
    input  logic signed [63:0] s_imm_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_insn_word,
    output logic               m_last,
    output logic               m_error,
    output logic               m_needs_reloc
);

    item_t       item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] word_reg;
    logic        last_reg;
    logic        err_reg;
    logic        reloc_reg;

    plan_t       plan;
    logic        out_load;
    logic        is_last;

    irae_encoder u_encoder (
        .item (item_reg),
        .plan (plan)
    );

    // Handshake and word sequencing
    assign out_load = item_valid_reg && (!m_valid_reg || m_ready);
    assign is_last  = (idx_reg == plan.last_idx);
    assign s_ready  = !item_valid_reg || (out_load && is_last);

    always_comb begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        m_valid_next    = m_valid_reg;
        if (s_ready) begin
            item_valid_next = s_valid;
        end
        if (out_load) begin
            idx_next     = is_last ? 2'd0 : idx_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Input payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command       <= s_command;
            item_reg.dest_present  <= s_dest_present;
            item_reg.dest_id       <= s_dest_id;
            item_reg.first_is_reg  <= s_first_is_reg;
            item_reg.first_id      <= s_first_id;
            item_reg.second_is_reg <= s_second_is_reg;
            item_reg.second_id     <= s_second_id;
            item_reg.imm_valid     <= s_imm_valid;
            item_reg.imm_value     <= s_imm_value;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            word_reg  <= plan.words[idx_reg];
            last_reg  <= is_last;
            err_reg   <= plan.err;
            reloc_reg <= plan.reloc;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_insn_word   = word_reg;
    assign m_last        = last_reg;
    assign m_error       = err_reg;
    assign m_needs_reloc = reloc_reg;

`ifndef SYNTHESIS
    // Word index never runs past the end of the current item's list
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> (idx_reg <= plan.last_idx))
        else $error("word index beyond item word count");

    // An error beat is a lone zero word
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && err_reg) |-> (last_reg && (word_reg == W_ERROR) && !reloc_reg))
        else $error("error beat malformed");

    // A relocation beat is the single BL word
    a_reloc_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && reloc_reg) |-> (last_reg && (word_reg == W_BL)))
        else $error("relocation beat malformed");

    // The input register frees only as its final word moves out
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && out_load && !is_last) |=> (item_valid_reg && (idx_reg != 2'd0)))
        else $error("item released before its last word");

    // An accepted beat is held in the input register next cycle
    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (item_valid_reg && (idx_reg == 2'd0)))
        else $error("accepted beat not captured");
`endif

endmodule

/* sv/irae_encoder.sv */
// Combinational decode of one registered item into its list of instruction words.
module irae_encoder
    import irae_pkg::*;
(
    input  item_t item,
    output plan_t plan
);

    logic [4:0]  dst;
    logic [4:0]  s0;
    logic [4:0]  s1;
    logic [15:0] part1;
    logic [15:0] part2;
    logic [15:0] part3;
    logic        p1;
    logic        p2;
    logic        p3;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;

    // Operand register mapping
    assign dst = item.dest_present ? map_reg(1'b1, item.dest_id) : REG_ZR;
    assign s0  = map_reg(item.first_is_reg, item.first_id);
    assign s1  = map_reg(item.second_is_reg, item.second_id);

    // Upper halfwords of a constant; zero ones get no MOVK
    assign part1 = item.imm_value[31:16];
    assign part2 = item.imm_value[47:32];
    assign part3 = item.imm_value[63:48];
    assign p1    = |part1;
    assign p2    = |part2;
    assign p3    = |part3;
    assign k1    = mov_wide(OPC_MOVK, dst, part1, 2'd1);
    assign k2    = mov_wide(OPC_MOVK, dst, part2, 2'd2);
    assign k3    = mov_wide(OPC_MOVK, dst, part3, 2'd3);

    always_comb begin
        plan          = '0;
        plan.words[0] = W_NOP;
        case (item.command)
            CMD_CONST: begin
                if (!item.imm_valid) begin
                    plan.words[0] = W_ERROR;
                    plan.err      = 1'b1;
                end else begin
                    // MOVZ, then the present MOVKs packed toward the front
                    plan.words[0] = mov_wide(OPC_MOVZ, dst, item.imm_value[15:0], 2'd0);
                    plan.words[1] = p1 ? k1 : (p2 ? k2 : k3);
                    plan.words[2] = (p1 && p2) ? k2 : k3;
                    plan.words[3] = k3;
                    plan.last_idx = 2'(p1) + 2'(p2) + 2'(p3);
                end
            end
            CMD_MOV: plan.words[0] = rrr(OP_ORR, s1, REG_ZR, s0);
            CMD_ADD: plan.words[0] = rrr(OP_ADD, dst, s0, s1);
            CMD_SUB: plan.words[0] = rrr(OP_SUB, dst, s0, s1);
            CMD_MUL: plan.words[0] = rrr(OP_MADD, dst, s0, s1) | 32'h00007C00;
            CMD_NEG: plan.words[0] = rrr(OP_SUB, dst, REG_ZR, s0);
            CMD_NOT: plan.words[0] = rrr(OP_ORR, dst, REG_ZR, s0) | 32'h00200000;
            CMD_AND: plan.words[0] = rrr(OP_AND, dst, s0, s1);
            CMD_OR:  plan.words[0] = rrr(OP_ORR, dst, s0, s1);
            CMD_XOR: plan.words[0] = rrr(OP_EOR, dst, s0, s1);
            CMD_EQ, CMD_NE, CMD_LT, CMD_LE, CMD_GT, CMD_GE: begin
                plan.words[0] = cmp_word(s0, s1);
                plan.words[1] = cset_word(dst, item.command);
                plan.last_idx = 2'd1;
            end
            CMD_BR: plan.words[0] = W_B;
            CMD_BRCOND: begin
                plan.words[0] = cmp_word(s0, REG_ZR);
                plan.words[1] = W_BNE;
                plan.words[2] = W_B_SKIP;
                plan.last_idx = 2'd2;
            end
            CMD_RET: plan.words[0] = W_RET;
            CMD_CALL: begin
                plan.words[0] = W_BL;
                plan.reloc    = 1'b1;
            end
            CMD_ALLOCA: plan.words[0] = W_ALLOCA;
            CMD_LOAD:   plan.words[0] = {OP_LDR, 2'b01, 12'd0, s0, dst};
            CMD_STORE:  plan.words[0] = {OP_STR, 2'b00, 12'd0, s0, s1};
            default:    plan.words[0] = W_NOP;
        endcase
    end

endmodule
